// ===== src/ugb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugb_pkg
// Shared types and constants of the uniform grid broadphase.
// ----------------------------------------------------------------------------
package ugb_pkg;

  localparam int DEF_GRID_CELLS    = 64;
  localparam int DEF_CELL_CAPACITY = 4;
  localparam int DEF_MAX_ENTITIES  = 256;
  localparam int DEF_HUGE_SLOTS    = 16;

  localparam logic [15:0] CELL_SIZE_RST = 16'd64;

  // Bits of the rounded position magnitude, one quotient bit per divider step.
  localparam int DIV_BITS = 16;

  // Neighborhood walk: own cell first, then the eight neighbors.
  localparam int NB_COUNT = 9;
  localparam logic signed [1:0] NB_DX [NB_COUNT] =
    '{2'sd0, -2'sd1, -2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] NB_DZ [NB_COUNT] =
    '{2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1};

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_MOVE,
    KIND_DELETE,
    KIND_QUERY
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_CELL_FULL,
    ST_HUGE_FULL,
    ST_ABSENT
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ENT,
    S_DIV,
    S_CHK,
    S_AP_RQ,
    S_AP_FILL,
    S_RM_RQ,
    S_RM_FILL,
    S_RM_SRQ,
    S_RM_SCAN,
    S_RM_LRQ,
    S_RM_LAST,
    S_AP_WR,
    S_Q_CELL,
    S_Q_FILL,
    S_Q_SRQ,
    S_Q_SLOT,
    S_Q_ENT,
    S_Q_PUSH,
    S_H_SCAN,
    S_FIN
  } state_t;

endpackage

// ===== src/uniform_grid_broadphase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_broadphase
// Square grid of bounded cell lists plus a list of gargantuan entities, with
// add, move, delete and collision-partner query words.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Contents
// in_*      slave      in_tvalid / in_tready       one command word
// out_*     master     out_tvalid / out_tready     result words, tlast on final
// cfg_*     write      cfg_we                      cell_size register
//
// After reset a clearing pass over max(GRID_CELLS^2, MAX_ENTITIES) addresses
// zeroes the fill counts and the entity table; no command word is taken
// meanwhile. One command word is worked on at a time. The two per-axis
// divisions run on one shared restoring divider, one quotient bit per cycle,
// for add and move; a cell removal reads and compares the cell slot by slot.
// A query walks nine cells, reading each cell's fill count and then its
// slots, then the valid slots of the gargantuan list.
// A stalled result output holds the sequencer at its next result word.
//
module uniform_grid_broadphase #(
  parameter int GRID_CELLS    = ugb_pkg::DEF_GRID_CELLS,
  parameter int CELL_CAPACITY = ugb_pkg::DEF_CELL_CAPACITY,
  parameter int MAX_ENTITIES  = ugb_pkg::DEF_MAX_ENTITIES,
  parameter int HUGE_SLOTS    = ugb_pkg::DEF_HUGE_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: entity[7:0], pos_x[31:8], pos_z[55:32], is_static[56],
  //        is_huge[57], scale[81:58], sleeping[82], zero fill [87:83]
  input  logic [87:0] in_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: partner[7:0], status[9:8], zero fill [15:10]
  output logic [15:0] out_tdata,
  // tuser: pair_valid[0]
  output logic        out_tuser,
  output logic        out_tlast,
  // Configuration.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // Geometry derived from the parameters.
  localparam int NCELLS   = GRID_CELLS * GRID_CELLS;
  localparam int NSLOTS   = NCELLS * CELL_CAPACITY;
  localparam int GW       = $clog2(GRID_CELLS);
  localparam int CW       = $clog2(NCELLS);
  localparam int SW       = $clog2(NSLOTS);
  localparam int FW       = $clog2(CELL_CAPACITY + 1);
  localparam int IW       = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
  localparam int EW       = $clog2(MAX_ENTITIES);
  localparam int HW       = (HUGE_SLOTS > 1) ? $clog2(HUGE_SLOTS) : 1;
  localparam int EIW      = 2 + 2 * GW;
  localparam int HALF     = GRID_CELLS / 2;
  localparam int POS_SAT  = GRID_CELLS - HALF;
  localparam int CLR_N    = (NCELLS > MAX_ENTITIES) ? NCELLS : MAX_ENTITIES;
  localparam int CLRW     = $clog2(CLR_N);
  localparam int DB       = ugb_pkg::DIV_BITS;

  // Rounded magnitude of a position: half away from zero, fraction dropped.
  function automatic logic [DB-1:0] round_mag(input logic [23:0] v);
    logic [24:0] mag;
    logic [24:0] sum;
    mag = v[23] ? (25'd0 - {v[23], v}) : {1'b0, v};
    sum = mag + 25'd128;
    return sum[23:8];
  endfunction

  // Grid index of one axis from the quotient and the sign of the position.
  function automatic logic [GW-1:0] axis_idx(input logic [DB-1:0] q, input logic neg);
    logic [GW-1:0] idx;
    if (!neg) begin
      idx = (q >= DB'(POS_SAT)) ? GW'(GRID_CELLS - 1) : GW'(q + DB'(HALF));
    end else begin
      idx = (q >= DB'(HALF)) ? '0 : GW'(DB'(HALF) - q);
    end
    return idx;
  endfunction

  function automatic logic [CW-1:0] cell_of(input logic [GW-1:0] x, input logic [GW-1:0] z);
    return CW'(x) * CW'(GRID_CELLS) + CW'(z);
  endfunction

  function automatic logic [SW-1:0] slot_addr(input logic [CW-1:0] c, input logic [IW-1:0] i);
    return SW'(c) * SW'(CELL_CAPACITY) + SW'(i);
  endfunction

  // Sequencer and command registers.
  ugb_pkg::state_t  state_r, state_nxt;
  ugb_pkg::kind_t   kind_r, kind_nxt;
  ugb_pkg::status_t status_r, status_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [23:0]      px_r, px_nxt;
  logic [23:0]      pz_r, pz_nxt;
  logic             st_in_r, st_in_nxt;
  logic             hg_r, hg_nxt;
  logic             sleep_r, sleep_nxt;
  logic [15:0]      cell_size_r, cell_size_nxt;
  logic [CLRW-1:0]  clr_r, clr_nxt;

  // Entity record read at the start of a command.
  logic             e_pres_r, e_pres_nxt;
  logic             e_stat_r, e_stat_nxt;
  logic [GW-1:0]    e_x_r, e_x_nxt;
  logic [GW-1:0]    e_z_r, e_z_nxt;

  // Shared divider.
  logic [DB-1:0]    rem_r, rem_nxt;
  logic [DB-1:0]    quo_r, quo_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic             axis_r, axis_nxt;
  logic [GW-1:0]    c_x_r, c_x_nxt;
  logic [GW-1:0]    c_z_r, c_z_nxt;

  // Cell removal and append.
  logic [FW-1:0]    rm_n_r, rm_n_nxt;
  logic [IW-1:0]    rm_i_r, rm_i_nxt;
  logic [FW-1:0]    ap_n_r, ap_n_nxt;

  // Query walk.
  logic [3:0]       nb_r, nb_nxt;
  logic [CW-1:0]    q_cell_r, q_cell_nxt;
  logic [FW-1:0]    qn_r, qn_nxt;
  logic [IW-1:0]    qs_r, qs_nxt;
  logic [7:0]       o_r, o_nxt;
  logic             ph_huge_r, ph_huge_nxt;
  logic [HW-1:0]    hidx_r, hidx_nxt;
  logic             held_v_r, held_v_nxt;
  logic [7:0]       held_id_r, held_id_nxt;

  // Gargantuan list.
  logic             huge_v_r [HUGE_SLOTS];
  logic             huge_v_nxt [HUGE_SLOTS];
  logic [7:0]       huge_id_r [HUGE_SLOTS];
  logic [7:0]       huge_id_nxt [HUGE_SLOTS];

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_partner_r, out_partner_nxt;
  logic             out_pv_r, out_pv_nxt;
  ugb_pkg::status_t out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  // Memory ports.
  logic             fill_we;
  logic [CW-1:0]    fill_waddr, fill_raddr;
  logic [FW-1:0]    fill_wdata, fill_rdata;
  logic             slot_we;
  logic [SW-1:0]    slot_waddr, slot_raddr;
  logic [7:0]       slot_wdata, slot_rdata;
  logic             ent_we;
  logic [EW-1:0]    ent_waddr, ent_raddr;
  logic [EIW-1:0]   ent_wdata, ent_rdata;

  // Shared combinational terms.
  logic             in_acc;
  logic             id_ok_in;
  logic             o_ok;
  logic             ent_pres, ent_stat;
  logic [GW-1:0]    ent_x, ent_z;
  logic [CW-1:0]    e_cell, c_cell;
  logic [15:0]      cs;
  logic [DB:0]      shifted;
  logic             ge;
  logic [DB-1:0]    div_q;
  logic [GW-1:0]    axis_res;
  logic signed [GW+1:0] nx, nz;
  logic             nb_in;
  logic             free_any;
  logic [HW-1:0]    free_idx;
  logic             fill_full;
  logic             scan_hit;
  logic             out_free;
  logic             nb_last, slot_last, h_last, rm_last;
  logic             move_same;
  ugb_pkg::state_t  nb_adv_st, q_adv_st, rm_done_st;

  ugb_ram #(.WIDTH(FW), .DEPTH(NCELLS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );

  ugb_ram #(.WIDTH(8), .DEPTH(NSLOTS)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  // Entity record: present, static, x cell, z cell.
  ugb_ram #(.WIDTH(EIW), .DEPTH(MAX_ENTITIES)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  assign in_tready  = (state_r == ugb_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign id_ok_in   = (32'(in_tdata[7:0]) < MAX_ENTITIES);
  assign o_ok       = (32'(o_r) < MAX_ENTITIES);

  assign ent_pres   = ent_rdata[EIW-1];
  assign ent_stat   = ent_rdata[EIW-2];
  assign ent_x      = ent_rdata[2*GW-1:GW];
  assign ent_z      = ent_rdata[GW-1:0];

  assign e_cell     = cell_of(e_x_r, e_z_r);
  assign c_cell     = cell_of(c_x_r, c_z_r);

  // A zero cell size divides as one.
  assign cs         = (cell_size_r == 16'd0) ? 16'd1 : cell_size_r;
  assign shifted    = {rem_r, quo_r[DB-1]};
  assign ge         = (shifted >= {1'b0, cs});
  assign div_q      = {quo_r[DB-2:0], ge};
  assign axis_res   = axis_idx(div_q, axis_r ? pz_r[23] : px_r[23]);

  assign nx         = $signed({2'b00, e_x_r}) + (GW+2)'(ugb_pkg::NB_DX[nb_r]);
  assign nz         = $signed({2'b00, e_z_r}) + (GW+2)'(ugb_pkg::NB_DZ[nb_r]);
  assign nb_in      = !nx[GW+1] && (nx < $signed((GW+2)'(GRID_CELLS))) &&
                      !nz[GW+1] && (nz < $signed((GW+2)'(GRID_CELLS)));

  assign fill_full  = (fill_rdata >= FW'(CELL_CAPACITY));
  assign scan_hit   = (slot_rdata == id_r);
  assign out_free   = !out_valid_r || out_tready;
  assign move_same  = (c_x_r == e_x_r) && (c_z_r == e_z_r);

  assign nb_last    = (nb_r == 4'(ugb_pkg::NB_COUNT - 1));
  assign slot_last  = ((FW'(qs_r) + FW'(1)) == qn_r);
  assign h_last     = (hidx_r == HW'(HUGE_SLOTS - 1));
  assign rm_last    = ((FW'(rm_i_r) + FW'(1)) == rm_n_r);

  assign nb_adv_st  = nb_last ? ugb_pkg::S_H_SCAN : ugb_pkg::S_Q_CELL;
  assign q_adv_st   = ph_huge_r ? (h_last ? ugb_pkg::S_FIN : ugb_pkg::S_H_SCAN)
                                : (slot_last ? nb_adv_st : ugb_pkg::S_Q_SRQ);

  // After a cell removal: add goes on to append, move writes its new cell,
  // delete is done.
  always_comb begin
    case (kind_r)
      ugb_pkg::KIND_ADD:  rm_done_st = ugb_pkg::S_AP_RQ;
      ugb_pkg::KIND_MOVE: rm_done_st = ugb_pkg::S_AP_WR;
      default:            rm_done_st = ugb_pkg::S_FIN;
    endcase
  end

  // Lowest free gargantuan slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int h = 0; h < HUGE_SLOTS; h++) begin
      if (!huge_v_r[h] && !free_any) begin
        free_any = 1'b1;
        free_idx = HW'(h);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ugb_pkg::S_CLEAR: begin
        if (clr_r == CLRW'(CLR_N - 1)) state_nxt = ugb_pkg::S_IDLE;
      end
      ugb_pkg::S_IDLE: begin
        if (in_acc) state_nxt = id_ok_in ? ugb_pkg::S_ENT : ugb_pkg::S_FIN;
      end
      ugb_pkg::S_ENT: begin
        case (kind_r)
          ugb_pkg::KIND_ADD:    state_nxt = ugb_pkg::S_DIV;
          ugb_pkg::KIND_MOVE:   state_nxt = ent_pres ? ugb_pkg::S_DIV : ugb_pkg::S_FIN;
          ugb_pkg::KIND_DELETE: state_nxt = ent_pres ? ugb_pkg::S_RM_RQ : ugb_pkg::S_FIN;
          default: begin
            state_nxt = (ent_pres && !ent_stat && !sleep_r) ? ugb_pkg::S_Q_CELL
                                                             : ugb_pkg::S_FIN;
          end
        endcase
      end
      ugb_pkg::S_DIV: begin
        if (bit_r == 4'(DB - 1) && axis_r) state_nxt = ugb_pkg::S_CHK;
      end
      ugb_pkg::S_CHK: begin
        if (kind_r == ugb_pkg::KIND_ADD) begin
          state_nxt = e_pres_r ? ugb_pkg::S_RM_RQ : ugb_pkg::S_AP_RQ;
        end else begin
          state_nxt = move_same ? ugb_pkg::S_FIN : ugb_pkg::S_AP_RQ;
        end
      end
      ugb_pkg::S_AP_RQ:   state_nxt = ugb_pkg::S_AP_FILL;
      ugb_pkg::S_AP_FILL: begin
        if (kind_r == ugb_pkg::KIND_ADD) begin
          state_nxt = (fill_full || (hg_r && !free_any)) ? ugb_pkg::S_FIN
                                                         : ugb_pkg::S_AP_WR;
        end else begin
          state_nxt = fill_full ? ugb_pkg::S_FIN : ugb_pkg::S_RM_RQ;
        end
      end
      ugb_pkg::S_RM_RQ:   state_nxt = ugb_pkg::S_RM_FILL;
      ugb_pkg::S_RM_FILL: begin
        state_nxt = (fill_rdata == '0) ? rm_done_st : ugb_pkg::S_RM_SRQ;
      end
      ugb_pkg::S_RM_SRQ:  state_nxt = ugb_pkg::S_RM_SCAN;
      ugb_pkg::S_RM_SCAN: begin
        if (scan_hit)     state_nxt = ugb_pkg::S_RM_LRQ;
        else if (rm_last) state_nxt = rm_done_st;
        else              state_nxt = ugb_pkg::S_RM_SRQ;
      end
      ugb_pkg::S_RM_LRQ:  state_nxt = ugb_pkg::S_RM_LAST;
      ugb_pkg::S_RM_LAST: state_nxt = rm_done_st;
      ugb_pkg::S_AP_WR:   state_nxt = ugb_pkg::S_FIN;
      ugb_pkg::S_Q_CELL:  state_nxt = nb_in ? ugb_pkg::S_Q_FILL : nb_adv_st;
      ugb_pkg::S_Q_FILL:  state_nxt = (fill_rdata == '0) ? nb_adv_st : ugb_pkg::S_Q_SRQ;
      ugb_pkg::S_Q_SRQ:   state_nxt = ugb_pkg::S_Q_SLOT;
      ugb_pkg::S_Q_SLOT:  state_nxt = ugb_pkg::S_Q_ENT;
      ugb_pkg::S_Q_ENT: begin
        if (ent_stat && o_ok && held_v_r) state_nxt = ugb_pkg::S_Q_PUSH;
        else                              state_nxt = q_adv_st;
      end
      ugb_pkg::S_Q_PUSH: begin
        if (out_free) state_nxt = q_adv_st;
      end
      ugb_pkg::S_H_SCAN: begin
        if (huge_v_r[hidx_r] && (32'(huge_id_r[hidx_r]) < MAX_ENTITIES)) begin
          state_nxt = ugb_pkg::S_Q_ENT;
        end else begin
          state_nxt = h_last ? ugb_pkg::S_FIN : ugb_pkg::S_H_SCAN;
        end
      end
      ugb_pkg::S_FIN: begin
        if (out_free) state_nxt = ugb_pkg::S_IDLE;
      end
      default: state_nxt = ugb_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory ports and output register.
  always_comb begin
    kind_nxt        = kind_r;
    status_nxt      = status_r;
    id_nxt          = id_r;
    px_nxt          = px_r;
    pz_nxt          = pz_r;
    st_in_nxt       = st_in_r;
    hg_nxt          = hg_r;
    sleep_nxt       = sleep_r;
    cell_size_nxt   = cfg_we ? cfg_wdata : cell_size_r;
    clr_nxt         = clr_r;
    e_pres_nxt      = e_pres_r;
    e_stat_nxt      = e_stat_r;
    e_x_nxt         = e_x_r;
    e_z_nxt         = e_z_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    bit_nxt         = bit_r;
    axis_nxt        = axis_r;
    c_x_nxt         = c_x_r;
    c_z_nxt         = c_z_r;
    rm_n_nxt        = rm_n_r;
    rm_i_nxt        = rm_i_r;
    ap_n_nxt        = ap_n_r;
    nb_nxt          = nb_r;
    q_cell_nxt      = q_cell_r;
    qn_nxt          = qn_r;
    qs_nxt          = qs_r;
    o_nxt           = o_r;
    ph_huge_nxt     = ph_huge_r;
    hidx_nxt        = hidx_r;
    held_v_nxt      = held_v_r;
    held_id_nxt     = held_id_r;
    huge_v_nxt      = huge_v_r;
    huge_id_nxt     = huge_id_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_partner_nxt = out_partner_r;
    out_pv_nxt      = out_pv_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;

    fill_we    = 1'b0;
    fill_waddr = e_cell;
    fill_wdata = '0;
    fill_raddr = c_cell;
    slot_we    = 1'b0;
    slot_waddr = slot_addr(e_cell, rm_i_r);
    slot_wdata = slot_rdata;
    slot_raddr = slot_addr(e_cell, rm_i_r);
    ent_we     = 1'b0;
    ent_waddr  = EW'(id_r);
    ent_wdata  = '0;
    ent_raddr  = EW'(id_r);

    unique case (state_r)
      ugb_pkg::S_CLEAR: begin
        clr_nxt    = clr_r + CLRW'(1);
        fill_we    = (32'(clr_r) < NCELLS);
        fill_waddr = CW'(clr_r);
        ent_we     = (32'(clr_r) < MAX_ENTITIES);
        ent_waddr  = EW'(clr_r);
      end
      ugb_pkg::S_IDLE: begin
        ent_raddr = EW'(in_tdata[7:0]);
        if (in_acc) begin
          kind_nxt   = ugb_pkg::kind_t'(in_tuser);
          id_nxt     = in_tdata[7:0];
          px_nxt     = in_tdata[31:8];
          pz_nxt     = in_tdata[55:32];
          st_in_nxt  = in_tdata[56];
          hg_nxt     = in_tdata[57] || (25'(in_tdata[81:58]) >= {cell_size_r, 9'd0});
          sleep_nxt  = in_tdata[82];
          status_nxt = id_ok_in ? ugb_pkg::ST_OK : ugb_pkg::ST_ABSENT;
          held_v_nxt = 1'b0;
        end
      end
      ugb_pkg::S_ENT: begin
        e_pres_nxt = ent_pres;
        e_stat_nxt = ent_stat;
        e_x_nxt    = ent_x;
        e_z_nxt    = ent_z;
        rem_nxt    = '0;
        quo_nxt    = round_mag(px_r);
        bit_nxt    = '0;
        axis_nxt   = 1'b0;
        nb_nxt     = '0;
        if (!ent_pres && kind_r != ugb_pkg::KIND_ADD) begin
          status_nxt = ugb_pkg::ST_ABSENT;
        end
        // Dropping an old registration clears its gargantuan entries at once.
        if (ent_pres && (kind_r == ugb_pkg::KIND_ADD || kind_r == ugb_pkg::KIND_DELETE)) begin
          for (int h = 0; h < HUGE_SLOTS; h++) begin
            if (huge_v_r[h] && huge_id_r[h] == id_r) huge_v_nxt[h] = 1'b0;
          end
        end
        if (ent_pres && kind_r == ugb_pkg::KIND_DELETE) begin
          ent_we    = 1'b1;
          ent_wdata = {2'b00, ent_x, ent_z};
        end
      end
      ugb_pkg::S_DIV: begin
        rem_nxt = ge ? DB'(shifted - {1'b0, cs}) : shifted[DB-1:0];
        quo_nxt = div_q;
        bit_nxt = bit_r + 4'd1;
        if (bit_r == 4'(DB - 1)) begin
          if (!axis_r) begin
            c_x_nxt  = axis_res;
            axis_nxt = 1'b1;
            rem_nxt  = '0;
            quo_nxt  = round_mag(pz_r);
            bit_nxt  = '0;
          end else begin
            c_z_nxt  = axis_res;
          end
        end
      end
      ugb_pkg::S_CHK: begin
      end
      ugb_pkg::S_AP_RQ: begin
        fill_raddr = c_cell;
      end
      ugb_pkg::S_AP_FILL: begin
        ap_n_nxt = fill_rdata;
        if (fill_full) begin
          status_nxt = ugb_pkg::ST_CELL_FULL;
        end else if (kind_r == ugb_pkg::KIND_ADD && hg_r && !free_any) begin
          status_nxt = ugb_pkg::ST_HUGE_FULL;
        end
        // A failed add leaves the entity absent.
        if (kind_r == ugb_pkg::KIND_ADD && (fill_full || (hg_r && !free_any))) begin
          ent_we    = 1'b1;
          ent_wdata = {2'b00, e_x_r, e_z_r};
        end
      end
      ugb_pkg::S_RM_RQ: begin
        fill_raddr = e_cell;
      end
      ugb_pkg::S_RM_FILL: begin
        rm_n_nxt = fill_rdata;
        rm_i_nxt = '0;
      end
      ugb_pkg::S_RM_SRQ: begin
        slot_raddr = slot_addr(e_cell, rm_i_r);
      end
      ugb_pkg::S_RM_SCAN: begin
        if (!scan_hit && !rm_last) rm_i_nxt = rm_i_r + IW'(1);
      end
      ugb_pkg::S_RM_LRQ: begin
        slot_raddr = slot_addr(e_cell, IW'(rm_n_r - FW'(1)));
      end
      ugb_pkg::S_RM_LAST: begin
        // The cell's last entry takes the removed entry's place.
        slot_we    = 1'b1;
        slot_waddr = slot_addr(e_cell, rm_i_r);
        slot_wdata = slot_rdata;
        fill_we    = 1'b1;
        fill_waddr = e_cell;
        fill_wdata = rm_n_r - FW'(1);
      end
      ugb_pkg::S_AP_WR: begin
        slot_we    = 1'b1;
        slot_waddr = slot_addr(c_cell, IW'(ap_n_r));
        slot_wdata = id_r;
        fill_we    = 1'b1;
        fill_waddr = c_cell;
        fill_wdata = ap_n_r + FW'(1);
        ent_we     = 1'b1;
        ent_wdata  = {1'b1, (kind_r == ugb_pkg::KIND_ADD) ? st_in_r : e_stat_r,
                      c_x_r, c_z_r};
        if (kind_r == ugb_pkg::KIND_ADD && hg_r) begin
          huge_v_nxt[free_idx]  = 1'b1;
          huge_id_nxt[free_idx] = id_r;
        end
      end
      ugb_pkg::S_Q_CELL: begin
        fill_raddr = cell_of(nx[GW-1:0], nz[GW-1:0]);
        q_cell_nxt = cell_of(nx[GW-1:0], nz[GW-1:0]);
        if (!nb_in) begin
          nb_nxt   = nb_r + 4'd1;
          hidx_nxt = '0;
        end
      end
      ugb_pkg::S_Q_FILL: begin
        qn_nxt = fill_rdata;
        qs_nxt = '0;
        if (fill_rdata == '0) begin
          nb_nxt   = nb_r + 4'd1;
          hidx_nxt = '0;
        end
      end
      ugb_pkg::S_Q_SRQ: begin
        slot_raddr = slot_addr(q_cell_r, qs_r);
      end
      ugb_pkg::S_Q_SLOT: begin
        o_nxt       = slot_rdata;
        ent_raddr   = EW'(slot_rdata);
        ph_huge_nxt = 1'b0;
      end
      ugb_pkg::S_Q_ENT, ugb_pkg::S_Q_PUSH: begin
        // The newest partner is held back so that the final one carries last.
        if (state_r == ugb_pkg::S_Q_ENT && ent_stat && o_ok && !held_v_r) begin
          held_v_nxt  = 1'b1;
          held_id_nxt = o_r;
        end
        if (state_r == ugb_pkg::S_Q_PUSH && out_free) begin
          out_valid_nxt   = 1'b1;
          out_partner_nxt = held_id_r;
          out_pv_nxt      = 1'b1;
          out_status_nxt  = ugb_pkg::ST_OK;
          out_last_nxt    = 1'b0;
          held_id_nxt     = o_r;
        end
        if ((state_r == ugb_pkg::S_Q_ENT && !(ent_stat && o_ok && held_v_r)) ||
            (state_r == ugb_pkg::S_Q_PUSH && out_free)) begin
          if (ph_huge_r) begin
            hidx_nxt = hidx_r + HW'(1);
          end else if (slot_last) begin
            nb_nxt   = nb_r + 4'd1;
            hidx_nxt = '0;
          end else begin
            qs_nxt = qs_r + IW'(1);
          end
        end
      end
      ugb_pkg::S_H_SCAN: begin
        ent_raddr   = EW'(huge_id_r[hidx_r]);
        o_nxt       = huge_id_r[hidx_r];
        ph_huge_nxt = 1'b1;
        if (!(huge_v_r[hidx_r] && (32'(huge_id_r[hidx_r]) < MAX_ENTITIES))) begin
          hidx_nxt = hidx_r + HW'(1);
        end
      end
      ugb_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_partner_nxt = held_v_r ? held_id_r : 8'd0;
          out_pv_nxt      = held_v_r;
          out_status_nxt  = status_r;
          out_last_nxt    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ugb_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cell_size_r <= ugb_pkg::CELL_SIZE_RST;
      for (int h = 0; h < HUGE_SLOTS; h++) huge_v_r[h] <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      cell_size_r <= cell_size_nxt;
      huge_v_r    <= huge_v_nxt;
    end
    kind_r        <= kind_nxt;
    status_r      <= status_nxt;
    id_r          <= id_nxt;
    px_r          <= px_nxt;
    pz_r          <= pz_nxt;
    st_in_r       <= st_in_nxt;
    hg_r          <= hg_nxt;
    sleep_r       <= sleep_nxt;
    e_pres_r      <= e_pres_nxt;
    e_stat_r      <= e_stat_nxt;
    e_x_r         <= e_x_nxt;
    e_z_r         <= e_z_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    bit_r         <= bit_nxt;
    axis_r        <= axis_nxt;
    c_x_r         <= c_x_nxt;
    c_z_r         <= c_z_nxt;
    rm_n_r        <= rm_n_nxt;
    rm_i_r        <= rm_i_nxt;
    ap_n_r        <= ap_n_nxt;
    nb_r          <= nb_nxt;
    q_cell_r      <= q_cell_nxt;
    qn_r          <= qn_nxt;
    qs_r          <= qs_nxt;
    o_r           <= o_nxt;
    ph_huge_r     <= ph_huge_nxt;
    hidx_r        <= hidx_nxt;
    held_v_r      <= held_v_nxt;
    held_id_r     <= held_id_nxt;
    huge_id_r     <= huge_id_nxt;
    out_partner_r <= out_partner_nxt;
    out_pv_r      <= out_pv_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_partner_r};
  assign out_tuser  = out_pv_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/ugb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ugb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
